### design/fvn2d_pkg.sv
// Shared types and constants for the fractal value noise unit.
// No dependencies; used by the octave cell, the divider cell and the top level.
`default_nettype none
package fvn2d_pkg;
	localparam logic [31:0] K_X       = 32'd374761393;
	localparam logic [31:0] K_Z       = 32'd668265263;
	localparam logic [31:0] K_SEED    = 32'd362437;
	localparam logic [31:0] K_SALT    = 32'd1013904223;
	localparam logic [31:0] K_MIX     = 32'd1274126177;
	localparam logic [31:0] SEED_STEP = 32'd7919;

	// wide enough for the largest octave count the unit supports
	localparam int SUM_W  = 36;
	localparam int NORM_W = 21;
	localparam int Q_W    = 16;

	typedef enum logic [2:0] {
		REG_SEED    = 3'd0,
		REG_SALT    = 3'd1,
		REG_OCTAVES = 3'd2,
		REG_LACUN   = 3'd3,
		REG_PERSIST = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] z;
		logic [15:0]        freq;
		logic [16:0]        amp;
		logic [SUM_W-1:0]   sum;
		logic [NORM_W-1:0]  norm;
	} cell_bus_t;

	typedef struct packed {
		cell_bus_t   bus;
		logic        act;
		logic [16:0] amp_now;
	} ride_t;

	typedef struct packed {
		logic [SUM_W-1:0]  rem;
		logic [NORM_W-1:0] norm;
		logic [Q_W-1:0]    quo;
		logic              zero;
	} div_bus_t;
endpackage
`default_nettype wire

### design/fvn2d_octave_cell.sv
// One octave of the noise chain: scale, hash four corners, smooth, blend, accumulate.
// Depends on fvn2d_pkg. Eight register stages, all advanced by en.
`default_nettype none
module fvn2d_octave_cell #(
	parameter int IDX       = 0,
	parameter int FRAC_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      in_vld,
	input  fvn2d_pkg::cell_bus_t     in_bus,
	input  wire  [31:0]              seed,
	input  wire  [31:0]              salt,
	input  wire  [4:0]               count,
	input  wire  [15:0]              lacun,
	input  wire  [16:0]              pers,
	output logic                     out_vld,
	output fvn2d_pkg::cell_bus_t     out_bus
);
	localparam int NR = 7;

	logic [NR-1:0]    vld_q;
	fvn2d_pkg::ride_t ride_q [NR];
	fvn2d_pkg::ride_t ride_in;
	fvn2d_pkg::cell_bus_t acc_bus;

	logic signed [48:0] px, pz;
	logic [31:0] nf, seed_i, seedt;
	logic [33:0] ap;
	logic [15:0] freq_nx;

	logic [31:0] px_s1, pz_s1, seedt_s1;
	logic [31:0] cx, cz;
	logic [15:0] fx, fz;
	logic [31:0] hx_s2, hz_s2, tx_s2, tz_s2, seedt_s2;
	logic [15:0] fx_s2, fz_s2;
	logic [31:0] m_s3 [4];
	logic [33:0] spx_s3, spz_s3;
	logic [31:0] g_s4 [4];
	logic [16:0] sx_s4, sz_s4, sz_s5;
	logic [15:0] h [4];
	logic [32:0] pa0_s5, pa1_s5, pb0_s5, pb1_s5, pc0_s6, pc1_s6, pv_s7;
	logic [33:0] sa, sb, sc;
	logic [17:0] wx, wz;

	assign px = $signed(in_bus.x) * $signed({1'b0, in_bus.freq});
	assign pz = $signed(in_bus.z) * $signed({1'b0, in_bus.freq});
	assign nf = 32'(in_bus.freq) * 32'(lacun);
	assign freq_nx = (|nf[31:24]) ? 16'hFFFF : nf[23:8];
	assign ap = 34'(in_bus.amp) * 34'(pers);
	assign seed_i = seed + 32'(IDX) * fvn2d_pkg::SEED_STEP;
	assign seedt = seed_i * fvn2d_pkg::K_SEED + salt * fvn2d_pkg::K_SALT;

	always_comb begin
		ride_in = '{bus: in_bus, act: (5'(IDX) < count), amp_now: in_bus.amp};
		ride_in.bus.freq = freq_nx;
		ride_in.bus.amp  = ap[32:16];
	end

	// split the scaled coordinate into cell and Q0.16 fraction
	assign cx = 32'($signed(px_s1) >>> FRAC_BITS);
	assign cz = 32'($signed(pz_s1) >>> FRAC_BITS);
	generate
		if (FRAC_BITS >= 16) begin : g_frac_hi
			assign fx = px_s1[FRAC_BITS-1 -: 16];
			assign fz = pz_s1[FRAC_BITS-1 -: 16];
		end else begin : g_frac_lo
			assign fx = {px_s1[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
			assign fz = {pz_s1[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
		end
	endgenerate

	assign wx = 18'd196608 - {1'b0, fx_s2, 1'b0};
	assign wz = 18'd196608 - {1'b0, fz_s2, 1'b0};

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			h[j] = g_s4[j][15:0] ^ g_s4[j][31:16];
		end
	end

	assign sa = 34'(pa0_s5) + 34'(pa1_s5);
	assign sb = 34'(pb0_s5) + 34'(pb1_s5);
	assign sc = 34'(pc0_s6) + 34'(pc1_s6);

	// accumulate only in active octaves, pass the running sums otherwise
	always_comb begin
		acc_bus = ride_q[NR-1].bus;
		if (ride_q[NR-1].act) begin
			acc_bus.sum  = ride_q[NR-1].bus.sum + fvn2d_pkg::SUM_W'(pv_s7);
			acc_bus.norm = ride_q[NR-1].bus.norm +
				fvn2d_pkg::NORM_W'(ride_q[NR-1].amp_now);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_q   <= {vld_q[NR-2:0], in_vld};
			out_vld <= vld_q[NR-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ride_q[0] <= ride_in;
			for (int k = 1; k < NR; k++) begin
				ride_q[k] <= ride_q[k-1];
			end
			// stage 1: scale by frequency, seed term
			px_s1    <= px[39:8];
			pz_s1    <= pz[39:8];
			seedt_s1 <= seedt;
			// stage 2: corner products, fraction squares
			hx_s2    <= cx * fvn2d_pkg::K_X;
			hz_s2    <= cz * fvn2d_pkg::K_Z;
			tx_s2    <= 32'(fx) * 32'(fx);
			tz_s2    <= 32'(fz) * 32'(fz);
			fx_s2    <= fx;
			fz_s2    <= fz;
			seedt_s2 <= seedt_s1;
			// stage 3: corner sums and first mix, smoothstep product
			for (int j = 0; j < 4; j++) begin
				m_s3[j] <= (hx_s2 + (j[0] ? fvn2d_pkg::K_X : 32'd0) + hz_s2 +
					(j[1] ? fvn2d_pkg::K_Z : 32'd0) + seedt_s2) ^
					((hx_s2 + (j[0] ? fvn2d_pkg::K_X : 32'd0) + hz_s2 +
					(j[1] ? fvn2d_pkg::K_Z : 32'd0) + seedt_s2) >> 13);
			end
			spx_s3 <= 34'(tx_s2[31:16]) * 34'(wx);
			spz_s3 <= 34'(tz_s2[31:16]) * 34'(wz);
			// stage 4: final hash multiply
			for (int j = 0; j < 4; j++) begin
				g_s4[j] <= m_s3[j] * fvn2d_pkg::K_MIX;
			end
			sx_s4 <= spx_s3[32:16];
			sz_s4 <= spz_s3[32:16];
			// stage 5: blend along x
			pa0_s5 <= 33'(h[0]) * 33'(17'd65536 - sx_s4);
			pa1_s5 <= 33'(h[1]) * 33'(sx_s4);
			pb0_s5 <= 33'(h[2]) * 33'(17'd65536 - sx_s4);
			pb1_s5 <= 33'(h[3]) * 33'(sx_s4);
			sz_s5  <= sz_s4;
			// stage 6: blend along z
			pc0_s6 <= 33'(sa[31:16]) * 33'(17'd65536 - sz_s5);
			pc1_s6 <= 33'(sb[31:16]) * 33'(sz_s5);
			// stage 7: weight by amplitude
			pv_s7 <= 33'(sc[31:16]) * 33'(ride_q[5].amp_now);
			// stage 8: accumulate
			out_bus <= acc_bus;
		end
	end
endmodule
`default_nettype wire

### design/fvn2d_div_cell.sv
// One quotient bit of the restoring divider that normalizes the octave sum.
// Depends on fvn2d_pkg.
`default_nettype none
module fvn2d_div_cell #(
	parameter int BIT = 0
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   in_vld,
	input  fvn2d_pkg::div_bus_t   in_bus,
	output logic                  out_vld,
	output fvn2d_pkg::div_bus_t   out_bus
);
	localparam int W = fvn2d_pkg::SUM_W + 1;

	logic [W-1:0] sh;
	logic         fit;
	fvn2d_pkg::div_bus_t nxt;

	assign sh  = W'(in_bus.norm) << BIT;
	assign fit = {1'b0, in_bus.rem} >= sh;

	always_comb begin
		nxt = in_bus;
		if (fit) begin
			nxt.rem      = fvn2d_pkg::SUM_W'({1'b0, in_bus.rem} - sh);
			nxt.quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_bus <= nxt;
		end
	end
endmodule
`default_nettype wire

### design/fractal_value_noise_2d_unit.sv
// Fractal value noise, 2D: top level with config registers, octave chain and divider.
// Depends on fvn2d_pkg, fvn2d_octave_cell and fvn2d_div_cell.
//
// Input channel: in_valid/in_stall with x_coord, z_coord (signed Q16.16).
// Output channel: out_valid/out_stall with noise_value (Q0.16).
// Config channel: cfg_valid/cfg_ready with cfg_index, cfg_data; cfg_ready is always high.
// Registers: 0 seed, 1 salt, 2 octave count, 3 lacunarity, 4 persistence.
// Write registers only when no transaction is in flight.
//
// Every octave cell is eight stages, the divider one stage per quotient bit; the
// latency does not depend on the octave count. One transaction is taken per cycle
// while the pipeline is not frozen: the whole pipeline moves on one enable.
// When out_valid is high and out_stall holds it, the pipeline freezes and in_stall
// rises in the same cycle; bubbles are not squeezed out.
// Reset clears all valid flags and loads the register defaults (seed 0, salt 0,
// four octaves, lacunarity 2.0, persistence 0.5).
`default_nettype none
module fractal_value_noise_2d_unit #(
	parameter int MAX_OCTAVES = 8,
	parameter int FRAC_BITS   = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire signed [31:0] x_coord,
	input  wire signed [31:0] z_coord,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [15:0]       noise_value,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [2:0]        cfg_index,
	input  wire  [31:0]       cfg_data
);
	localparam int QW = fvn2d_pkg::Q_W;

	logic [31:0] noise_seed_q, hash_salt_q;
	logic [3:0]  octave_count_q;
	logic [15:0] lacunarity_q;
	logic [16:0] persistence_q;
	logic [4:0]  count_sat;
	logic [16:0] pers_sat;
	logic        en;

	fvn2d_pkg::cell_bus_t obus [MAX_OCTAVES+1];
	logic                 ovld [MAX_OCTAVES+1];
	fvn2d_pkg::div_bus_t  dbus [QW+1];
	logic                 dvld [QW+1];

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_seed_q   <= '0;
			hash_salt_q    <= '0;
			octave_count_q <= 4'd4;
			lacunarity_q   <= 16'd512;
			persistence_q  <= 17'd32768;
		end else if (cfg_valid && cfg_ready) begin
			unique case (fvn2d_pkg::cfg_reg_t'(cfg_index))
				fvn2d_pkg::REG_SEED:    noise_seed_q   <= cfg_data;
				fvn2d_pkg::REG_SALT:    hash_salt_q    <= cfg_data;
				fvn2d_pkg::REG_OCTAVES: octave_count_q <= cfg_data[3:0];
				fvn2d_pkg::REG_LACUN:   lacunarity_q   <= cfg_data[15:0];
				fvn2d_pkg::REG_PERSIST: persistence_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign count_sat = (5'(octave_count_q) > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
		: 5'(octave_count_q);
	assign pers_sat  = (persistence_q > 17'd65536) ? 17'd65536 : persistence_q;

	assign ovld[0] = in_valid && en;
	assign obus[0] = '{x: x_coord, z: z_coord, freq: 16'd256, amp: 17'd65536,
		sum: '0, norm: '0};

	generate
		for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
			fvn2d_octave_cell #(.IDX(i), .FRAC_BITS(FRAC_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.in_vld(ovld[i]), .in_bus(obus[i]),
				.seed(noise_seed_q), .salt(hash_salt_q), .count(count_sat),
				.lacun(lacunarity_q), .pers(pers_sat),
				.out_vld(ovld[i+1]), .out_bus(obus[i+1])
			);
		end
	endgenerate

	assign dvld[0] = ovld[MAX_OCTAVES];
	assign dbus[0] = '{rem: obus[MAX_OCTAVES].sum, norm: obus[MAX_OCTAVES].norm,
		quo: '0, zero: (obus[MAX_OCTAVES].norm == '0)};

	// most significant quotient bit first
	generate
		for (genvar k = 0; k < QW; k++) begin : g_div
			fvn2d_div_cell #(.BIT(QW-1-k)) u_div (
				.clk(clk), .arst_n(arst_n), .en(en),
				.in_vld(dvld[k]), .in_bus(dbus[k]),
				.out_vld(dvld[k+1]), .out_bus(dbus[k+1])
			);
		end
	endgenerate

	assign out_valid   = dvld[QW];
	assign noise_value = dbus[QW].zero ? '0 : dbus[QW].quo;
endmodule
`default_nettype wire

### design/fvn2d_checker.sv
// Port-level checks for fractal_value_noise_2d_unit, attached by bind.
// Depends only on the top level's ports.
`default_nettype none
module fvn2d_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [15:0] noise_value,
	input wire        cfg_valid,
	input wire        cfg_ready
);
	// input is held back only by a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	a_val_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(noise_value))
		else $error("stalled result changed");
endmodule

bind fractal_value_noise_2d_unit fvn2d_checker u_fvn2d_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
`default_nettype wire
